// ----- rtl/mbe_pkg.sv -----
// Shared types and constants for the escape-time core.
package mbe_pkg;

  localparam int FRAC_BITS = 28;
  localparam int COORD_W   = 10;
  localparam int REG_W     = 32;
  localparam int COUNT_W   = 11;
  localparam int C_W       = 44;   // wide enough for origin + coord * step
  localparam int Z_W       = 31;   // z after the bound check, each component within +/-2.0
  localparam int PROD_W    = 2 * REG_W;
  localparam int ADDR_W    = 3;

  localparam logic signed [PROD_W-1:0] TWO_Q28  = PROD_W'(64'sd2) <<< FRAC_BITS;
  localparam logic signed [PROD_W-1:0] FOUR_Q56 = PROD_W'(64'sd4) <<< (2 * FRAC_BITS);

  typedef enum logic [ADDR_W-1:0] {
    REG_RE_ORIGIN = 3'd0,
    REG_IM_ORIGIN = 3'd1,
    REG_RE_STEP   = 3'd2,
    REG_IM_STEP   = 3'd3,
    REG_MAX_ITER  = 3'd4
  } reg_idx_e;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_CR   = 8'b0000_0010,
    ST_CI   = 8'b0000_0100,
    ST_MRR  = 8'b0000_1000,
    ST_MII  = 8'b0001_0000,
    ST_TEST = 8'b0010_0000,
    ST_UPD  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } seq_state_e;

  typedef struct packed {
    logic signed [REG_W-1:0] re_origin;
    logic signed [REG_W-1:0] im_origin;
    logic signed [REG_W-1:0] re_step;
    logic signed [REG_W-1:0] im_step;
    logic [COUNT_W-1:0]      limit;
  } cfg_t;

  typedef struct packed {
    logic signed [REG_W-1:0] a;
    logic signed [REG_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COUNT_W-1:0] count;
    logic               escaped;
  } result_t;

endpackage

// ----- rtl/mbe_mul.sv -----
// Shared signed multiplier with a registered product.
module mbe_mul (
  input  logic                                   clk_i,
  input  mbe_pkg::mul_req_t                      req_i,
  output logic signed [mbe_pkg::PROD_W-1:0]      prod_o
);
  import mbe_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(req_i.a) * PROD_W'(req_i.b);
  end

  assign prod_o = prod_q;

endmodule

// ----- rtl/mbe_seq.sv -----
// Sequencer and datapath for one pixel: forms c, then runs z = z*z + c.
module mbe_seq (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mbe_pkg::cfg_t                     cfg_i,
  input  logic                              start_i,
  input  logic [mbe_pkg::COORD_W-1:0]       col_i,
  input  logic [mbe_pkg::COORD_W-1:0]       row_i,
  input  logic                              slot_free_i,
  input  logic signed [mbe_pkg::PROD_W-1:0] prod_i,
  output logic                              idle_o,
  output mbe_pkg::mul_req_t                 mul_o,
  output mbe_pkg::result_t                  res_o
);
  import mbe_pkg::*;

  seq_state_e state_q, state_d;
  logic [COORD_W-1:0]      col_q, col_d, row_q, row_d;
  logic [COUNT_W-1:0]      k_q, k_d;
  logic                    first_q, first_d;
  logic                    esc_q, esc_d;
  logic signed [C_W-1:0]   cr_q, cr_d, ci_q, ci_d;
  logic signed [Z_W-1:0]   zr_q, zr_d, zi_q, zi_d;
  logic signed [PROD_W-1:0] sr_q, sr_d, si_q, si_d;

  logic signed [PROD_W-1:0] mag_sum, nr, ni;
  logic [COUNT_W-1:0]       k_next;

  always_comb begin
    mag_sum = sr_q + prod_i;
    nr      = ((sr_q - si_q) >>> FRAC_BITS) + PROD_W'(cr_q);
    ni      = ((prod_i <<< 1) >>> FRAC_BITS) + PROD_W'(ci_q);
    k_next  = first_q ? '0 : k_q + COUNT_W'(1);
  end

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    k_d     = k_q;
    first_d = first_q;
    esc_d   = esc_q;
    cr_d    = cr_q;
    ci_d    = ci_q;
    zr_d    = zr_q;
    zi_d    = zi_q;
    sr_d    = sr_q;
    si_d    = si_q;
    mul_o.a = REG_W'(zr_q);
    mul_o.b = REG_W'(zr_q);

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          col_d   = col_i;
          row_d   = row_i;
          k_d     = '0;
          first_d = 1'b1;
          esc_d   = 1'b0;
          zr_d    = '0;
          zi_d    = '0;
          state_d = ST_CR;
        end
      end
      ST_CR: begin
        mul_o.a = REG_W'(col_q);
        mul_o.b = cfg_i.re_step;
        state_d = ST_CI;
      end
      ST_CI: begin
        cr_d    = prod_i[C_W-1:0] + C_W'(cfg_i.re_origin);
        mul_o.a = REG_W'(row_q);
        mul_o.b = cfg_i.im_step;
        state_d = ST_MRR;
      end
      ST_MRR: begin
        // on the first pass this slot also lands ci
        if (first_q) begin
          ci_d = prod_i[C_W-1:0] + C_W'(cfg_i.im_origin);
        end
        state_d = ST_MII;
      end
      ST_MII: begin
        sr_d    = prod_i;
        mul_o.a = REG_W'(zi_q);
        mul_o.b = REG_W'(zi_q);
        state_d = ST_TEST;
      end
      ST_TEST: begin
        si_d    = prod_i;
        mul_o.a = REG_W'(zr_q);
        mul_o.b = REG_W'(zi_q);
        if (mag_sum > FOUR_Q56) begin
          esc_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          k_d     = k_next;
          first_d = 1'b0;
          state_d = (k_next >= cfg_i.limit) ? ST_DONE : ST_UPD;
        end
      end
      ST_UPD: begin
        if (nr > TWO_Q28 || nr < -TWO_Q28 || ni > TWO_Q28 || ni < -TWO_Q28) begin
          esc_d   = 1'b1;
          state_d = ST_DONE;
        end else begin
          zr_d    = nr[Z_W-1:0];
          zi_d    = ni[Z_W-1:0];
          state_d = ST_MRR;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the item
        if (slot_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      first_q <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
    row_q <= row_d;
    k_q   <= k_d;
    esc_q <= esc_d;
    cr_q  <= cr_d;
    ci_q  <= ci_d;
    zr_q  <= zr_d;
    zi_q  <= zi_d;
    sr_q  <= sr_d;
    si_q  <= si_d;
  end

  assign idle_o        = (state_q == ST_IDLE);
  assign res_o.valid   = (state_q == ST_DONE) && slot_free_i;
  assign res_o.col     = col_q;
  assign res_o.row     = row_q;
  assign res_o.count   = k_q;
  assign res_o.escaped = esc_q;

endmodule

// ----- rtl/mandelbrot_escape_time_core.sv -----
// Top level of the escape-time core: config registers, stream ports, result register.
//
//  channel   dir  handshake                         payload
//  s_axis    in   s_axis_tvalid / s_axis_tready     tdata: pixel_col, pixel_row
//  m_axis    out  m_axis_tvalid / m_axis_tready     tdata: out_col, out_row,
//                                                          iteration_count, escaped
//  cfg       in   cfg_we_i (no back-pressure)       cfg_addr_i, cfg_wdata_i
//
// A result is ready when the iteration count reaches the limit, when a component of z
// passes 2.0 (checked in ST_UPD) or when |z|^2 passes 4 (checked in ST_TEST); the
// sequencer then holds in ST_DONE until the output register is free and returns to idle
// before it takes the next item. The one shared 32x32 multiplier issues three products
// in each iteration (zr^2, zi^2, zr*zi) and forms c in ST_CR and ST_CI before the first.
// Reset restores the register defaults and empties the result register.
// s_axis_tready is high only while no item is in work; a result waits in the
// output register and the next item may be accepted meanwhile.
module mandelbrot_escape_time_core #(
  parameter int ITERATION_CAP = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mbe_pkg::ADDR_W-1:0]  cfg_addr_i,
  input  logic [mbe_pkg::REG_W-1:0]   cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [23:0]                 s_axis_tdata,   // pixel_col[9:0], pixel_row[19:10]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata    // out_col[9:0], out_row[19:10],
                                                      // iteration_count[30:20], escaped[31]
);
  import mbe_pkg::*;

  localparam int CapClip = (ITERATION_CAP > (2 ** COUNT_W) - 1) ?
                           (2 ** COUNT_W) - 1 : ITERATION_CAP;
  localparam logic [COUNT_W-1:0] LimitCap = COUNT_W'(CapClip);

  logic signed [REG_W-1:0] re_origin_q, im_origin_q, re_step_q, im_step_q;
  logic [COUNT_W-1:0]      max_iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      re_origin_q <= -32'sd536870912;
      im_origin_q <= -32'sd536870912;
      re_step_q   <= 32'sd1048576;
      im_step_q   <= 32'sd1048576;
      max_iter_q  <= 11'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_RE_ORIGIN: re_origin_q <= cfg_wdata_i;
        REG_IM_ORIGIN: im_origin_q <= cfg_wdata_i;
        REG_RE_STEP:   re_step_q   <= cfg_wdata_i;
        REG_IM_STEP:   im_step_q   <= cfg_wdata_i;
        REG_MAX_ITER:  max_iter_q  <= cfg_wdata_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  cfg_t     cfg;
  mul_req_t mul_req;
  result_t  res;
  logic signed [PROD_W-1:0] prod;
  logic idle, slot_free;

  assign cfg.re_origin = re_origin_q;
  assign cfg.im_origin = im_origin_q;
  assign cfg.re_step   = re_step_q;
  assign cfg.im_step   = im_step_q;
  assign cfg.limit     = (max_iter_q > LimitCap) ? LimitCap : max_iter_q;

  mbe_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  mbe_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start_i     (s_axis_tvalid && idle),
    .col_i       (s_axis_tdata[COORD_W-1:0]),
    .row_i       (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .slot_free_i (slot_free),
    .prod_i      (prod),
    .idle_o      (idle),
    .mul_o       (mul_req),
    .res_o       (res)
  );

  logic        out_valid_q;
  logic [31:0] out_data_q;

  assign slot_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_data_q <= {res.escaped, res.count, res.row, res.col};
    end
  end

  assign s_axis_tready = idle;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
